// ===== design/stcr_pkg.sv =====
// Shared types, constants and glyph table for the character rasterizer.
package stcr_pkg;

  localparam int GLYPH_COUNT   = 97;
  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 8;

  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h80;
  localparam logic [7:0] TEXT_PITCH = 8'd6;

  localparam logic       REQ_START   = 1'b0;
  localparam logic       REQ_ADVANCE = 1'b1;

  localparam logic [2:0] REG_PEN_ENABLE    = 3'd0;
  localparam logic [2:0] REG_TILT_ENABLE   = 3'd1;
  localparam logic [2:0] REG_VERTICAL_MODE = 3'd2;
  localparam logic [2:0] REG_SCALE_X       = 3'd3;
  localparam logic [2:0] REG_SCALE_Y       = 3'd4;

  typedef struct packed {
    logic       pen_enable;
    logic       tilt_enable;
    logic       vertical_mode;
    logic [3:0] scale_x;
    logic [3:0] scale_y;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    logic        last;
    logic        plot_en;
    logic [2:0]  bit_sel;
    logic [6:0]  glyph;
    logic [2:0]  column;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] next_x;
    logic [15:0] next_y;
  } step_t;

  localparam logic [7:0] FONT_ROM [GLYPH_COUNT][GLYPH_COLUMNS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h03,8'h00,8'h03,8'h00}, '{8'h0A,8'h1F,8'h0A,8'h1F,8'h0A},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h00,8'h0B,8'h07,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h2A,8'h1C,8'h7F,8'h1C,8'h2A}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h00,8'hB0,8'h70,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h41,8'h41,8'h3E,8'h00}, '{8'h00,8'h02,8'h7F,8'h00,8'h00},
    '{8'h62,8'h51,8'h49,8'h49,8'h46}, '{8'h41,8'h41,8'h49,8'h4D,8'h33},
    '{8'h0F,8'h08,8'h08,8'h7F,8'h08}, '{8'h47,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h61,8'h11,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'hB6,8'h76,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h3E,8'h41,8'h5D,8'h55,8'h5E}, '{8'h7E,8'h09,8'h09,8'h09,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h40,8'h40,8'h3F}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h02,8'h04,8'h08,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h26,8'h49,8'h49,8'h49,8'h32},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h7F,8'h02,8'h04}, '{8'h08,8'h1C,8'h2A,8'h08,8'h08},
    '{8'h00,8'h07,8'h0B,8'h00,8'h00}, '{8'h70,8'h54,8'h54,8'h78,8'h40},
    '{8'h40,8'h7F,8'h44,8'h44,8'h3C}, '{8'h00,8'h38,8'h44,8'h44,8'h48},
    '{8'h38,8'h44,8'h44,8'h7F,8'h40}, '{8'h00,8'h38,8'h54,8'h54,8'h48},
    '{8'h00,8'h08,8'h7C,8'h0A,8'h02}, '{8'h00,8'h98,8'hA4,8'hA4,8'h7C},
    '{8'h00,8'h7F,8'h04,8'h04,8'h78}, '{8'h00,8'h00,8'h7A,8'h00,8'h00},
    '{8'h00,8'h40,8'h80,8'h74,8'h00}, '{8'h00,8'h7E,8'h10,8'h28,8'h44},
    '{8'h00,8'h02,8'h7E,8'h40,8'h00}, '{8'h7C,8'h04,8'h7C,8'h04,8'h78},
    '{8'h00,8'h7C,8'h04,8'h04,8'h78}, '{8'h00,8'h38,8'h44,8'h44,8'h38},
    '{8'h00,8'hFC,8'h24,8'h24,8'h18}, '{8'h18,8'h24,8'h24,8'hFC,8'h80},
    '{8'h00,8'h7C,8'h08,8'h04,8'h04}, '{8'h00,8'h48,8'h54,8'h54,8'h24},
    '{8'h00,8'h04,8'h3E,8'h44,8'h20}, '{8'h3C,8'h40,8'h40,8'h7C,8'h40},
    '{8'h0C,8'h30,8'h40,8'h30,8'h0C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h24,8'h38,8'h48,8'h44}, '{8'h00,8'h1C,8'h20,8'hA0,8'hFC},
    '{8'h40,8'h64,8'h54,8'h4C,8'h04}, '{8'h00,8'h08,8'h36,8'h41,8'h41},
    '{8'h00,8'h00,8'h77,8'h00,8'h00}, '{8'h00,8'h41,8'h41,8'h36,8'h08},
    '{8'h08,8'h08,8'h08,8'h08,8'h38}, '{8'h55,8'h2A,8'h55,8'h2A,8'h55},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF}
  };

endpackage

// ===== design/stcr_glyph_rom.sv =====
// Glyph column ROM with a registered read port.
module stcr_glyph_rom (
  input  logic       clk,
  input  logic       rd_en,
  input  logic [6:0] rd_glyph,
  input  logic [2:0] rd_column,
  output logic [7:0] rd_data_r
);
  import stcr_pkg::*;

  logic [7:0] rd_data_nxt;

  always_comb begin
    if (rd_glyph < 7'(GLYPH_COUNT) && rd_column < 3'(GLYPH_COLUMNS)) begin
      rd_data_nxt = FONT_ROM[rd_glyph][rd_column];
    end else if (rd_column < 3'(GLYPH_COLUMNS)) begin
      rd_data_nxt = FONT_ROM[0][rd_column];
    end else begin
      rd_data_nxt = FONT_ROM[0][0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rd_data_nxt;
    end
  end

endmodule

// ===== design/stcr_walker.sv =====
// Character state and raster walk: counters, coordinates and next position.
module stcr_walker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic            req_type,
  input  logic [7:0]      char_code,
  input  logic [15:0]     ref_x,
  input  logic [15:0]     ref_y,
  input  stcr_pkg::cfg_t  cfg,
  output stcr_pkg::step_t step
);
  import stcr_pkg::*;

  logic        busy_r, busy_nxt;
  logic [6:0]  glyph_r, glyph_nxt;
  logic [15:0] org_x_r, org_x_nxt;
  logic [15:0] org_y_r, org_y_nxt;
  logic [2:0]  col_idx_r, col_idx_nxt;
  logic [3:0]  col_rep_r, col_rep_nxt;
  logic [2:0]  row_idx_r, row_idx_nxt;
  logic [3:0]  row_rep_r, row_rep_nxt;

  logic [4:0]  sx, sy;
  logic [7:0]  c_off, v_off, skew, pitch;
  logic        last_step;

  always_comb begin
    sx = (cfg.scale_x == 4'd0) ? 5'd16 : {1'b0, cfg.scale_x};
    sy = (cfg.scale_y == 4'd0) ? 5'd16 : {1'b0, cfg.scale_y};
    c_off = 8'({5'd0, col_idx_r} * {3'd0, sx}) + {4'd0, col_rep_r};
    v_off = 8'({5'd0, row_idx_r} * {3'd0, sy}) + {4'd0, row_rep_r};
    skew  = cfg.tilt_enable ? v_off : 8'd0;
    pitch = 8'({3'd0, sx} * TEXT_PITCH);

    busy_nxt    = busy_r;
    glyph_nxt   = glyph_r;
    org_x_nxt   = org_x_r;
    org_y_nxt   = org_y_r;
    col_idx_nxt = col_idx_r;
    col_rep_nxt = col_rep_r;
    row_idx_nxt = row_idx_r;
    row_rep_nxt = row_rep_r;
    last_step   = 1'b0;

    if (({1'b0, row_rep_r} + 5'd1) < sy) begin
      row_rep_nxt = row_rep_r + 4'd1;
    end else begin
      row_rep_nxt = 4'd0;
      if (row_idx_r < 3'(GLYPH_ROWS - 1)) begin
        row_idx_nxt = row_idx_r + 3'd1;
      end else begin
        row_idx_nxt = 3'd0;
        if (({1'b0, col_rep_r} + 5'd1) < sx) begin
          col_rep_nxt = col_rep_r + 4'd1;
        end else begin
          col_rep_nxt = 4'd0;
          if (({1'b0, col_idx_r} + 4'd1) < 4'(GLYPH_COLUMNS)) begin
            col_idx_nxt = col_idx_r + 3'd1;
          end else begin
            col_idx_nxt = 3'd0;
            last_step   = 1'b1;
          end
        end
      end
    end

    step.emit    = acc && req_type == REQ_ADVANCE && busy_r;
    step.plot_en = cfg.pen_enable;
    step.bit_sel = 3'(GLYPH_ROWS - 1) - row_idx_r;
    step.glyph   = glyph_r;
    step.column  = (col_idx_r < 3'(GLYPH_COLUMNS)) ? col_idx_r : 3'd0;
    step.next_x  = cfg.vertical_mode ? org_x_r : org_x_r + {8'd0, pitch};
    step.next_y  = cfg.vertical_mode ? org_y_r + {8'd0, pitch} : org_y_r;
    if (!cfg.pen_enable) begin
      step.pixel_x = org_x_r;
      step.pixel_y = org_y_r;
      step.last    = 1'b1;
    end else if (cfg.vertical_mode) begin
      step.pixel_x = org_x_r + {8'd0, v_off};
      step.pixel_y = org_y_r - {8'd0, c_off} - {8'd0, skew};
      step.last    = last_step;
    end else begin
      step.pixel_x = org_x_r + {8'd0, c_off} + {8'd0, skew};
      step.pixel_y = org_y_r + {8'd0, v_off};
      step.last    = last_step;
    end

    if (acc && req_type == REQ_START) begin
      busy_nxt    = 1'b1;
      glyph_nxt   = (char_code < CODE_FIRST || char_code > CODE_LAST) ?
                    7'd0 : 7'(char_code - CODE_FIRST);
      org_x_nxt   = ref_x;
      org_y_nxt   = ref_y;
      col_idx_nxt = 3'd0;
      col_rep_nxt = 4'd0;
      row_idx_nxt = 3'd0;
      row_rep_nxt = 4'd0;
    end else if (step.emit) begin
      if (!cfg.pen_enable) begin
        busy_nxt    = 1'b0;
        col_idx_nxt = col_idx_r;
        col_rep_nxt = col_rep_r;
        row_idx_nxt = row_idx_r;
        row_rep_nxt = row_rep_r;
      end else if (last_step) begin
        busy_nxt = 1'b0;
      end
    end else begin
      col_idx_nxt = col_idx_r;
      col_rep_nxt = col_rep_r;
      row_idx_nxt = row_idx_r;
      row_rep_nxt = row_rep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      glyph_r   <= 7'd0;
      org_x_r   <= 16'd0;
      org_y_r   <= 16'd0;
      col_idx_r <= 3'd0;
      col_rep_r <= 4'd0;
      row_idx_r <= 3'd0;
      row_rep_r <= 4'd0;
    end else begin
      busy_r    <= busy_nxt;
      glyph_r   <= glyph_nxt;
      org_x_r   <= org_x_nxt;
      org_y_r   <= org_y_nxt;
      col_idx_r <= col_idx_nxt;
      col_rep_r <= col_rep_nxt;
      row_idx_r <= row_idx_nxt;
      row_rep_r <= row_rep_nxt;
    end
  end

endmodule

// ===== design/scaled_tilted_char_rasterizer.sv =====
// Top level: config registers, ROM read stage and output register.
// An advance transfer's result reaches out_tvalid through the registered
// glyph ROM read stage and then the output register.
// One item per cycle while out_tready is high; a start or idle advance yields no result.
// Synchronous active-low reset: config to pen on, no tilt, horizontal,
// scale 1x1; no character active; pipeline empty.
module scaled_tilted_char_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // char_code, ref_x, ref_y
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // pixel_x, pixel_y, next_x, next_y
  output logic        out_tuser,  // plot
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import stcr_pkg::*;

  cfg_t  cfg_r;
  step_t step;
  step_t b_step_r;
  logic  b_valid_r, c_valid_r;
  logic  in_acc, c_free, b_to_c;
  logic [7:0]  rom_q;
  logic        c_plot_r, c_last_r;
  logic [63:0] c_data_r;

  assign cfg_ready = 1'b1;
  assign c_free    = !c_valid_r || out_tready;
  assign in_tready = !b_valid_r || c_free;
  assign in_acc    = in_tvalid && in_tready;
  assign b_to_c    = b_valid_r && c_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pen_enable    <= 1'b1;
      cfg_r.tilt_enable   <= 1'b0;
      cfg_r.vertical_mode <= 1'b0;
      cfg_r.scale_x       <= 4'd1;
      cfg_r.scale_y       <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PEN_ENABLE:    cfg_r.pen_enable    <= cfg_data[0];
        REG_TILT_ENABLE:   cfg_r.tilt_enable   <= cfg_data[0];
        REG_VERTICAL_MODE: cfg_r.vertical_mode <= cfg_data[0];
        REG_SCALE_X:       cfg_r.scale_x       <= cfg_data;
        REG_SCALE_Y:       cfg_r.scale_y       <= cfg_data;
        default: ;
      endcase
    end
  end

  stcr_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .req_type  (in_tuser),
    .char_code (in_tdata[7:0]),
    .ref_x     (in_tdata[23:8]),
    .ref_y     (in_tdata[39:24]),
    .cfg       (cfg_r),
    .step      (step)
  );

  stcr_glyph_rom u_rom (
    .clk       (clk),
    .rd_en     (step.emit),
    .rd_glyph  (step.glyph),
    .rd_column (step.column),
    .rd_data_r (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (step.emit) begin
        b_valid_r <= 1'b1;
      end else if (b_to_c) begin
        b_valid_r <= 1'b0;
      end
      if (b_to_c) begin
        c_valid_r <= 1'b1;
      end else if (out_tready) begin
        c_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step.emit) begin
      b_step_r <= step;
    end
    if (b_to_c) begin
      c_plot_r <= b_step_r.plot_en && rom_q[b_step_r.bit_sel];
      c_last_r <= b_step_r.last;
      c_data_r <= {b_step_r.next_y, b_step_r.next_x, b_step_r.pixel_y, b_step_r.pixel_x};
    end
  end

  assign out_tvalid = c_valid_r;
  assign out_tdata  = c_data_r;
  assign out_tuser  = c_plot_r;
  assign out_tlast  = c_last_r;

  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == REQ_START) |=> (b_valid_r == ($past(b_valid_r) && !$past(c_free))))
    else $error("start transfer produced a result");

  a_rom_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !c_free) |=> $stable(rom_q))
    else $error("glyph data changed while stalled");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (b_valid_r && c_valid_r))
    else $error("input stalled with room in pipeline");

  a_b_load: assert property (@(posedge clk) disable iff (!rst_n)
    step.emit |-> in_tready)
    else $error("step issued without space");

endmodule

// ===== dv/tb_scaled_tilted_char_rasterizer.sv =====
// Self-checking testbench for the scaled, tilted 5x8 character rasterizer.
`timescale 1ns / 1ps

module tb_scaled_tilted_char_rasterizer;
  import stcr_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic        plot;
    logic        last;
    logic [15:0] next_x;
    logic [15:0] next_y;
  } raster_px_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [3:0]  reg_val;
    logic        req;
    logic [7:0]  code;
    logic [15:0] x;
    logic [15:0] y;
    bit          pinned;
    raster_px_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // char_code, ref_x, ref_y
  logic        in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // pixel_x, pixel_y, next_x, next_y
  logic        out_tuser;  // plot
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;

  // expectation attached to the item being offered
  bit          drv_pinned;
  raster_px_t  drv_want;

  // predictor copy of the registers and the character walk
  logic        pen_on      = 1'b1;
  logic        tilt_on     = 1'b0;
  logic        vert_on     = 1'b0;
  logic [3:0]  scale_x_reg = 4'd1;
  logic [3:0]  scale_y_reg = 4'd1;
  logic        char_active = 1'b0;
  logic [6:0]  glyph_sel   = '0;
  logic [15:0] org_x       = '0;
  logic [15:0] org_y       = '0;
  logic [2:0]  col_idx     = '0;
  logic [3:0]  col_rep     = '0;
  logic [2:0]  row_idx     = '0;
  logic [3:0]  row_rep     = '0;

  raster_px_t  pending_px[$];
  stim_row_t   dir_rows[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;

  scaled_tilted_char_rasterizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic raster_px_t mk_px(input logic [15:0] px, input logic [15:0] py,
                                       input logic plot, input logic last,
                                       input logic [15:0] nx, input logic [15:0] ny);
    raster_px_t r;
    r.pixel_x = px;
    r.pixel_y = py;
    r.plot    = plot;
    r.last    = last;
    r.next_x  = nx;
    r.next_y  = ny;
    return r;
  endfunction

  // Applies one accepted item to the predicted state; returns 1 with the raster step
  // when the item yields a result.
  function automatic bit next_raster_step(input logic req, input logic [7:0] code,
                                          input logic [15:0] ref_x, input logic [15:0] ref_y,
                                          output raster_px_t res);
    int         sx;
    int         sy;
    int         c;
    int         v;
    int         skew;
    logic [6:0] gi;
    logic [7:0] column_bits;
    res = '0;
    sx = (scale_x_reg == 4'd0) ? 16 : int'(scale_x_reg);
    sy = (scale_y_reg == 4'd0) ? 16 : int'(scale_y_reg);
    if (req == REQ_START) begin
      glyph_sel = (code < CODE_FIRST || code > CODE_LAST) ? 7'd0 : 7'(code - CODE_FIRST);
      org_x = ref_x;
      org_y = ref_y;
      col_idx = '0;
      col_rep = '0;
      row_idx = '0;
      row_rep = '0;
      char_active = 1'b1;
      return 1'b0;
    end
    if (!char_active) return 1'b0;

    res.next_x = org_x;
    res.next_y = org_y;
    if (vert_on) res.next_y = org_y + 16'(int'(TEXT_PITCH) * sx);
    else res.next_x = org_x + 16'(int'(TEXT_PITCH) * sx);

    if (!pen_on) begin
      res.pixel_x = org_x;
      res.pixel_y = org_y;
      res.last = 1'b1;
      char_active = 1'b0;
      return 1'b1;
    end

    gi = (int'(glyph_sel) < GLYPH_COUNT) ? glyph_sel : 7'd0;
    column_bits = FONT_ROM[gi][(int'(col_idx) < GLYPH_COLUMNS) ? col_idx : 3'd0];
    res.plot = column_bits[3'd7 - row_idx];
    c = int'(col_idx) * sx + int'(col_rep);
    v = int'(row_idx) * sy + int'(row_rep);
    skew = tilt_on ? v : 0;
    if (vert_on) begin
      res.pixel_x = org_x + 16'(v);
      res.pixel_y = org_y - 16'(c) - 16'(skew);
    end else begin
      res.pixel_x = org_x + 16'(c + skew);
      res.pixel_y = org_y + 16'(v);
    end

    // bit repeat, bit, column repeat, column; a counter at or past a shrunk scale moves on
    if (int'(row_rep) + 1 < sy) begin
      row_rep++;
    end else begin
      row_rep = '0;
      if (int'(row_idx) < GLYPH_ROWS - 1) begin
        row_idx++;
      end else begin
        row_idx = '0;
        if (int'(col_rep) + 1 < sx) begin
          col_rep++;
        end else begin
          col_rep = '0;
          if (int'(col_idx) + 1 < GLYPH_COLUMNS) begin
            col_idx++;
          end else begin
            col_idx = '0;
            res.last = 1'b1;
            char_active = 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    raster_px_t got;
    raster_px_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PEN_ENABLE:    pen_on = cfg_data[0];
          REG_TILT_ENABLE:   tilt_on = cfg_data[0];
          REG_VERTICAL_MODE: vert_on = cfg_data[0];
          REG_SCALE_X:       scale_x_reg = cfg_data;
          REG_SCALE_Y:       scale_y_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = mk_px(out_tdata[15:0], out_tdata[31:16], out_tuser, out_tlast,
                    out_tdata[47:32], out_tdata[63:48]);
        if (pending_px.size() == 0) begin
          flag_error($sformatf("unexpected transfer x=%h y=%h", got.pixel_x, got.pixel_y));
        end else begin
          want = pending_px.pop_front();
          if (got.pixel_x !== want.pixel_x)
            flag_error($sformatf("pixel_x got %h want %h", got.pixel_x, want.pixel_x));
          if (got.pixel_y !== want.pixel_y)
            flag_error($sformatf("pixel_y got %h want %h", got.pixel_y, want.pixel_y));
          if (got.plot !== want.plot)
            flag_error($sformatf("plot got %b want %b", got.plot, want.plot));
          if (got.last !== want.last)
            flag_error($sformatf("last got %b want %b", got.last, want.last));
          if (got.next_x !== want.next_x)
            flag_error($sformatf("next_x got %h want %h", got.next_x, want.next_x));
          if (got.next_y !== want.next_y)
            flag_error($sformatf("next_y got %h want %h", got.next_y, want.next_y));
        end
      end
      if (in_tvalid && in_tready) begin
        if (next_raster_step(in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[39:24], want))
          pending_px.push_back(drv_pinned ? drv_want : want);
      end
    end
  end

  // result side: random ready bursts, one long hold-off, steady ready at the end
  initial begin : receiver
    int   len;
    logic lvl;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        len = HOLD_CYCLES;
        lvl = 1'b0;
      end else if (quiet) begin
        len = 1;
        lvl = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(1, 18);
        lvl = 1'b0;
      end else begin
        len = $urandom_range(1, 40);
        lvl = 1'b1;
      end
      repeat (len) begin
        out_tready <= lvl;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic drive_item(input logic req, input logic [7:0] code,
                            input logic [15:0] x, input logic [15:0] y,
                            input bit pinned, input raster_px_t want);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= req;
    in_tdata   <= {y, x, code};
    drv_pinned <= pinned;
    drv_want   <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic void add_cfg(input logic [2:0] idx, input logic [3:0] val);
    stim_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.req     = REQ_ADVANCE;
    r.code    = '0;
    r.x       = '0;
    r.y       = '0;
    r.pinned  = 1'b0;
    r.want    = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_item(input logic req, input logic [7:0] code,
                                   input logic [15:0] x, input logic [15:0] y);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.req     = req;
    r.code    = code;
    r.x       = x;
    r.y       = y;
    r.pinned  = 1'b0;
    r.want    = '0;
    dir_rows.push_back(r);
  endfunction

  // advance whose result is known up front
  function automatic void add_check(input raster_px_t want);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    dir_rows[dir_rows.size() - 1].pinned = 1'b1;
    dir_rows[dir_rows.size() - 1].want = want;
  endfunction

  function automatic logic [3:0] pick_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 4'($urandom_range(1, 2));
    if (r == 6) return 4'd3;
    if (r == 7) return 4'd0;
    if (r == 8) return 4'd15;
    return 4'($urandom_range(4, 14));
  endfunction

  task automatic run_phase(input int budget);
    int         sent;
    int         n;
    int         sxe;
    int         sye;
    logic       pen;
    logic [3:0] sx;
    logic [3:0] sy;
    logic [7:0] code;
    pen = ($urandom_range(0, 5) != 0);
    sx = pick_scale();
    sy = pick_scale();
    wait_idle();
    write_reg(REG_PEN_ENABLE, {3'($urandom_range(0, 7)), pen});
    write_reg(REG_TILT_ENABLE, 4'($urandom_range(0, 15)));
    write_reg(REG_VERTICAL_MODE, 4'($urandom_range(0, 15)));
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    cfg_valid <= 1'b0;
    sxe = (sx == 4'd0) ? 16 : int'(sx);
    sye = (sy == 4'd0) ? 16 : int'(sy);
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        code = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                           : 8'($urandom_range(CODE_FIRST, CODE_LAST));
        drive_item(REQ_START, code, 16'($urandom), 16'($urandom), 1'b0, '0);
        n = pen ? GLYPH_COLUMNS * GLYPH_ROWS * sxe * sye : 1;
        if (n > 200 || $urandom_range(0, 5) == 0) n = $urandom_range(1, (n > 80) ? 80 : n);
        else n += $urandom_range(0, 1);
        repeat (n)
          drive_item(REQ_ADVANCE, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
        sent += n + 1;
      end else begin
        drive_item(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom), 16'($urandom),
                   1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int i;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_START;
    cfg_valid  = 1'b0;
    cfg_index  = REG_PEN_ENABLE;
    cfg_data   = '0;
    drv_pinned = 1'b0;
    drv_want   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_item(REQ_ADVANCE, 8'hA5, 16'h5A5A, 16'hA5A5);    // nothing started: ignored
    add_item(REQ_START, 8'h41, 16'hFFFF, 16'hFFFF);
    add_check(mk_px(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0005, 16'hFFFF));
    add_check(mk_px(16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0005, 16'hFFFF));
    add_item(REQ_START, 8'h00, 16'h0000, 16'h0000);      // replaces a busy character
    add_check(mk_px(16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0006, 16'h0000));
    add_item(REQ_START, CODE_LAST, 16'd100, 16'd200);    // solid block glyph
    add_check(mk_px(16'd100, 16'd200, 1'b1, 1'b0, 16'd106, 16'd200));
    add_item(REQ_START, 8'h81, 16'h1234, 16'h0000);
    add_check(mk_px(16'h1234, 16'h0000, 1'b0, 1'b0, 16'h123A, 16'h0000));
    add_item(REQ_START, 8'hFF, 16'h8000, 16'h7FFF);
    add_item(REQ_ADVANCE, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_item(REQ_START, 8'h1F, 16'h00FF, 16'hFF00);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    add_item(REQ_START, 8'h7F, 16'hFFF0, 16'h000F);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    add_item(REQ_START, CODE_FIRST, 16'h0001, 16'hFFFE);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    add_cfg(REG_TILT_ENABLE, 4'd1);
    add_cfg(REG_VERTICAL_MODE, 4'd1);
    add_cfg(REG_SCALE_X, 4'd0);
    add_cfg(REG_SCALE_Y, 4'd0);
    add_item(REQ_START, 8'h57, 16'h0010, 16'h0008);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    add_cfg(REG_SCALE_X, 4'd2);                          // shrink scales mid-character
    add_cfg(REG_SCALE_Y, 4'd1);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);
    add_cfg(REG_PEN_ENABLE, 4'd0);                       // pen off ends the character
    add_check(mk_px(16'h0010, 16'h0008, 1'b0, 1'b1, 16'h0010, 16'h0014));
    add_item(REQ_ADVANCE, 8'h00, 16'h0000, 16'h0000);

    @(posedge clk);
    for (i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].is_cfg) begin
        if (i == 0 || !dir_rows[i - 1].is_cfg) wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        if (i + 1 == dir_rows.size() || !dir_rows[i + 1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        drive_item(dir_rows[i].req, dir_rows[i].code, dir_rows[i].x, dir_rows[i].y,
                   dir_rows[i].pinned, dir_rows[i].want);
      end
    end

    hold_request = 1'b1;
    for (i = 0; i < PHASES; i++) begin
      if (i == PHASES - 2) quiet = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_px.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_px.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
